// ===== rtl/round_robin_tag_allocator_top_defines.svh =====
// Assertion macros for the round-robin tag allocator.
`ifndef ROUND_ROBIN_TAG_ALLOCATOR_TOP_DEFINES_SVH
`define ROUND_ROBIN_TAG_ALLOCATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RRTA_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RRTA_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define RRTA_CHECK(lbl, clk, rst, prop, msg)
`define RRTA_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/rrta_pkg.sv =====
// Shared types and constants for the round-robin tag allocator.
package rrta_pkg;

  localparam int DEF_QUEUES = 4;
  localparam int DEF_TAGS   = 64;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_BIND   = 2'd1,
    CMD_UNBIND = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } ctl_stat_t;

endpackage

// ===== rtl/rrta_pick.sv =====
// Rotating find-first-free over one queue's tag bitmap.
module rrta_pick #(
  parameter int TAGS = rrta_pkg::DEF_TAGS,
  parameter int TW   = $clog2(TAGS)
) (
  input  logic [TAGS-1:0] free,
  input  logic [TW-1:0]   start,
  output logic            found,
  output logic [TW-1:0]   pick
);
  import rrta_pkg::*;

  logic [TAGS-1:0] hi;
  logic [TAGS-1:0] sel;
  logic [TAGS-1:0] iso;

  always_comb begin
    hi    = free & ({TAGS{1'b1}} << start);
    sel   = (|hi) ? hi : free;
    // isolate lowest set bit, then encode
    iso   = sel & (~sel + TAGS'(1));
    found = |free;
    pick  = '0;
    for (int i = 0; i < TAGS; i++) begin
      if (iso[i]) begin
        pick = pick | TW'(i);
      end
    end
  end

endmodule

// ===== rtl/rrta_ctrl.sv =====
// Controller state machine: accept a beat, then commit it to the output register.
module rrta_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrta_pkg::ctl_stat_t stat,
  output rrta_pkg::ctl_cmd_t  ctl
);
  import rrta_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_EXEC: begin
        ctl.commit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/rrta_dp.sv =====
// Datapath: handle RAM, in-use bitmap, per-queue pointers and result register.
module rrta_dp #(
  parameter int QUEUES = rrta_pkg::DEF_QUEUES,
  parameter int TAGS   = rrta_pkg::DEF_TAGS
) (
  input  logic                clk,
  input  logic                rst,
  input  rrta_pkg::ctl_cmd_t  ctl,
  output rrta_pkg::ctl_stat_t stat,
  input  logic [1:0]          cmd,
  input  logic [2:0]          queue_sel,
  input  logic [6:0]          tag,
  input  logic [31:0]         request_handle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [5:0]          tag_out,
  output logic [31:0]         handle_out
);
  import rrta_pkg::*;

  localparam int TW     = $clog2(TAGS);
  localparam int QW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int DEPTH  = QUEUES * TAGS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]     mem [DEPTH];
  logic [31:0]     rd_data;
  logic [TAGS-1:0] used [QUEUES];
  logic [TW-1:0]   ptr [QUEUES];

  cmd_t            cmd_q;
  logic [2:0]      queue_q;
  logic [6:0]      tag_q;
  logic [31:0]     handle_q;
  logic [ADDR_W-1:0] addr_in;
  logic [ADDR_W-1:0] addr_q;

  status_t         status_q;
  logic [5:0]      tag_out_q;
  logic [31:0]     handle_out_q;

  logic            q_ok;
  logic            t_ok;
  logic [QW-1:0]   qi;
  logic [TW-1:0]   ti;
  logic [TAGS-1:0] row;
  logic [TAGS-1:0] free;
  logic [31:0]     stored;
  logic [TW-1:0]   p;
  logic [TW-1:0]   start;
  logic            found;
  logic [TW-1:0]   pick;
  logic [TW:0]     pick_inc;
  logic [TW-1:0]   ptr_nx;

  status_t         status_next;
  logic [5:0]      tag_out_next;
  logic [31:0]     handle_out_next;
  logic            mem_wr;
  logic            bit_wr;
  logic            bit_val;
  logic            ptr_wr;

  assign addr_in = ADDR_W'(32'(queue_sel) * TAGS + 32'(tag));

  // capture the beat; the handle RAM read is registered with it
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q    <= cmd_t'(cmd);
      queue_q  <= queue_sel;
      tag_q    <= tag;
      handle_q <= request_handle;
      addr_q   <= addr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && mem_wr) begin
      mem[addr_q] <= handle_q;
    end
    if (ctl.capture) begin
      rd_data <= mem[addr_in];
    end
  end

  always_comb begin
    q_ok  = 32'(queue_q) < QUEUES;
    t_ok  = 32'(tag_q) < TAGS;
    qi    = q_ok ? QW'(queue_q) : '0;
    ti    = t_ok ? TW'(tag_q) : '0;
    row   = used[qi];
    free  = ~row;
    free[0] = 1'b0;   // tag 0 is never handed out
    // RAM content only counts where the in-use flag is set
    stored = row[ti] ? rd_data : 32'd0;
    p     = ptr[qi];
    start = (p == '0 || 32'(p) >= TAGS) ? TW'(1) : p;
  end

  rrta_pick #(
    .TAGS (TAGS),
    .TW   (TW)
  ) u_pick (
    .free  (free),
    .start (start),
    .found (found),
    .pick  (pick)
  );

  always_comb begin
    pick_inc = {1'b0, pick} + (TW+1)'(1);
    ptr_nx   = (32'(pick_inc) >= TAGS) ? TW'(1) : pick_inc[TW-1:0];
  end

  always_comb begin
    status_next     = STATUS_OK;
    tag_out_next    = 6'd0;
    handle_out_next = 32'd0;
    mem_wr          = 1'b0;
    bit_wr          = 1'b0;
    bit_val         = 1'b0;
    ptr_wr          = 1'b0;
    if (!q_ok) begin
      status_next = STATUS_INVALID;
    end else begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (found) begin
            tag_out_next = 6'(pick);
            ptr_wr       = 1'b1;
          end else begin
            status_next = STATUS_FULL;
          end
        end
        CMD_BIND: begin
          if (!t_ok) begin
            status_next = STATUS_INVALID;
          end else begin
            mem_wr  = 1'b1;
            bit_wr  = 1'b1;
            bit_val = |handle_q;
          end
        end
        CMD_UNBIND: begin
          if (!t_ok) begin
            status_next = STATUS_INVALID;
          end else if (stored == handle_q) begin
            bit_wr = 1'b1;
          end
        end
        CMD_LOOKUP: begin
          if (!t_ok) begin
            status_next = STATUS_INVALID;
          end else begin
            handle_out_next = stored;
          end
        end
        default: status_next = STATUS_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        used[i] <= '0;
        ptr[i]  <= TW'(1);
      end
    end else if (ctl.commit) begin
      if (bit_wr) used[qi][ti] <= bit_val;
      if (ptr_wr) ptr[qi] <= ptr_nx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status_q     <= status_next;
      tag_out_q    <= tag_out_next;
      handle_out_q <= handle_out_next;
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign status        = status_q;
  assign tag_out       = tag_out_q;
  assign handle_out    = handle_out_q;

endmodule

// ===== rtl/round_robin_tag_allocator_top.sv =====
// Top level of the round-robin tag allocator.
// Each command beat is handled in order: first register the command and read the
// handle RAM (QUEUES*TAGS words, one read port), then resolve against the
// queue's in-use bitmap and pointer, update state and load the result register.
// A new beat is not accepted until the current one has committed; a result
// held by out_ready low stalls the resolve step. Allocate finds the next free
// tag at or after the queue pointer in one pass over the bitmap, skipping tag 0,
// and does not claim it. The in-use flags clear at reset, so no clearing pass of
// the handle RAM is needed and a beat may arrive straight after reset.
`include "round_robin_tag_allocator_top_defines.svh"

module round_robin_tag_allocator_top #(
  parameter int QUEUES = rrta_pkg::DEF_QUEUES,
  parameter int TAGS   = rrta_pkg::DEF_TAGS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [2:0]  queue_sel,
  input  logic [6:0]  tag,
  input  logic [31:0] request_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  tag_out,
  output logic [31:0] handle_out
);
  import rrta_pkg::*;

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  rrta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  rrta_dp #(
    .QUEUES (QUEUES),
    .TAGS   (TAGS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .cmd            (cmd),
    .queue_sel      (queue_sel),
    .tag            (tag),
    .request_handle (request_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .tag_out        (tag_out),
    .handle_out     (handle_out)
  );

  `RRTA_CHECK(a_two_cycle, clk, rst, (in_valid && in_ready) |=> !in_ready, "beat accepted on consecutive cycles")
  `RRTA_CHECK(a_rise_commit, clk, rst, $rose(out_valid) |-> $past(ctl.commit), "result appeared without a commit")
  `RRTA_CHECK(a_err_zero, clk, rst, (out_valid && status != STATUS_OK) |-> (tag_out == 6'd0 && handle_out == 32'd0), "non-zero payload on error status")
  `RRTA_NEVER(a_commit_blocked, clk, rst, ctl.commit && out_valid && !out_ready, "commit overwrote a pending result")

endmodule
